// ===== rtl/core/pidaw_pkg.sv =====
// shared constants and types for the pid controller with back-calculation anti-windup
`default_nettype none
package pidaw_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int INTEG_W        = 48;
    localparam int WGAIN_W        = 17;
    localparam int TERM_W         = 62;
    localparam int TERM_LIMIT_EXP = 60;
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEG_GAIN    = 3'd1,
        REG_DERIV_GAIN    = 3'd2,
        REG_TARGET_VALUE  = 3'd3,
        REG_SAMPLE_PERIOD = 3'd4,
        REG_DRIVE_FLOOR   = 3'd5,
        REG_DRIVE_CEILING = 3'd6,
        REG_WINDUP_GAIN   = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_MSTART,
        ST_MWAIT,
        ST_DWAIT,
        ST_SUM,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_INC,
        OP_PROP,
        OP_INTEG,
        OP_DERIV,
        OP_CORR
    } op_t;

endpackage
`default_nettype wire

// ===== rtl/core/pid_controller_back_calc_antiwindup_unit.sv =====
// top level of the pid controller with back-calculation anti-windup
//
// channel   direction  ports                                   role
// cfg       in         cfg_valid/ready, cfg_index, cfg_data    register write
// s_        in         s_valid/ready, s_process_value          process sample
// m_        out        m_valid/ready, m_drive, m_raw_drive,    controller result
//                      m_was_clamped
//
// one sample runs through the bit-serial multiplier (one multiplier bit a cycle,
// five products, four when the sample period is zero) and the restoring divider
// (one quotient bit a cycle over the whole product)
// reset is synchronous, active low; it restores register defaults and clears
// the integral and the previous error
// a new sample is taken only when the sequencer is idle; the result register
// lets the next sample be taken while a result still waits on m_ready
`default_nettype none
module pid_controller_back_calc_antiwindup_unit #(
    parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pidaw_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pidaw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [DATA_WIDTH-1:0]               cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [DATA_WIDTH-1:0]        s_process_value,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [DATA_WIDTH-1:0]             m_drive,
    output logic signed [DATA_WIDTH-1:0]             m_raw_drive,
    output logic                                     m_was_clamped
);
    import pidaw_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int AW = (INTEG_W > DW + 1) ? INTEG_W : DW + 1;
    localparam int BW = (DW > WGAIN_W) ? DW : WGAIN_W;
    localparam int PW = AW + BW;
    localparam int SW = TERM_W + 2;

    // register defaults
    localparam logic signed [DW-1:0] PROP_RST   = DW'(1) << FRAC_BITS;
    localparam logic signed [DW-1:0] CEIL_RST   = DW'(100) << FRAC_BITS;
    localparam logic [DW-2:0]        PERIOD_RST = (DW-1)'(1) << FRAC_BITS;
    localparam logic [WGAIN_W-1:0]   WGAIN_RST  =
        WGAIN_W'((2 ** (FRAC_BITS + 1) + 10) / 20);

    // saturation bounds
    localparam logic [PW-1:0]        LIMIT_P = PW'(1) << TERM_LIMIT_EXP;
    localparam logic signed [SW-1:0] IMAX_S  = SW'($signed({1'b0, {(INTEG_W-1){1'b1}}}));
    localparam logic signed [SW-1:0] IMIN_S  = SW'($signed({1'b1, {(INTEG_W-1){1'b0}}}));
    localparam logic signed [SW-1:0] DMAX_S  = SW'($signed({1'b0, {(DW-1){1'b1}}}));
    localparam logic signed [SW-1:0] DMIN_S  = SW'($signed({1'b1, {(DW-1){1'b0}}}));

    // configuration registers
    logic signed [DW-1:0] kp_reg, ki_reg, kd_reg, sp_reg, lo_reg, hi_reg;
    logic [DW-2:0]        dt_reg;
    logic [WGAIN_W-1:0]   aw_reg;

    // sequencer and datapath
    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   neg_reg;

    logic signed [DW-1:0]      err_reg, prev_err_reg, raw_reg, drv_reg;
    logic signed [DW:0]        diff_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [TERM_W-1:0]  pterm_reg, iterm_reg, dterm_reg;

    logic                 m_valid_reg;
    logic signed [DW-1:0] m_drive_reg, m_raw_reg;
    logic                 m_clamp_reg;

    // control
    logic take_in, mul_start, div_start, emit;

    // arithmetic nets
    logic signed [DW:0]        err_wide;
    logic signed [DW-1:0]      err_sat;
    logic signed [DW:0]        corr_in;
    logic signed [AW-1:0]      a_sig;
    logic signed [BW:0]        b_sig;
    logic [AW-1:0]             a_mag;
    logic [BW-1:0]             b_mag;
    logic                      mul_done, div_done;
    logic [PW-1:0]             prod, quo;
    logic [PW-1:0]             prod_shift, frac_mag, quo_mag;
    logic signed [TERM_W-1:0]  frac_term, quo_term;
    logic signed [SW-1:0]      integ_add;
    logic signed [INTEG_W-1:0] integ_sat;
    logic signed [SW-1:0]      sum3;
    logic signed [DW-1:0]      raw_sat;
    logic signed [DW-1:0]      drv_hi, drv_c;

    // register writes, always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg <= PROP_RST;
            ki_reg <= '0;
            kd_reg <= '0;
            sp_reg <= '0;
            dt_reg <= PERIOD_RST;
            lo_reg <= '0;
            hi_reg <= CEIL_RST;
            aw_reg <= WGAIN_RST;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PROP_GAIN:     kp_reg <= cfg_data;
                REG_INTEG_GAIN:    ki_reg <= cfg_data;
                REG_DERIV_GAIN:    kd_reg <= cfg_data;
                REG_TARGET_VALUE:  sp_reg <= cfg_data;
                REG_SAMPLE_PERIOD: dt_reg <= cfg_data[DW-2:0];
                REG_DRIVE_FLOOR:   lo_reg <= cfg_data;
                REG_DRIVE_CEILING: hi_reg <= cfg_data;
                REG_WINDUP_GAIN:   aw_reg <= WGAIN_W'(cfg_data);
                default:           kp_reg <= kp_reg;
            endcase
        end
    end

    // error = setpoint - sample, saturated to data width
    assign err_wide = (DW+1)'(sp_reg) - (DW+1)'(s_process_value);

    always_comb begin
        if (err_wide[DW] != err_wide[DW-1]) begin
            err_sat = err_wide[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            err_sat = err_wide[DW-1:0];
        end
    end

    // back-calculation difference, clamped minus raw
    assign corr_in = (DW+1)'(drv_reg) - (DW+1)'(raw_reg);

    // operand select for the shared multiplier
    always_comb begin
        case (op_reg)
            OP_INC: begin
                a_sig = AW'(err_reg);
                b_sig = $signed((BW+1)'(dt_reg));
            end
            OP_PROP: begin
                a_sig = AW'(err_reg);
                b_sig = (BW+1)'(kp_reg);
            end
            OP_INTEG: begin
                a_sig = AW'(integ_reg);
                b_sig = (BW+1)'(ki_reg);
            end
            OP_DERIV: begin
                a_sig = AW'(diff_reg);
                b_sig = (BW+1)'(kd_reg);
            end
            OP_CORR: begin
                a_sig = AW'(corr_in);
                b_sig = $signed((BW+1)'(aw_reg));
            end
            default: begin
                a_sig = '0;
                b_sig = '0;
            end
        endcase
    end

    assign a_mag = a_sig[AW-1] ? AW'(-a_sig) : AW'(a_sig);
    assign b_mag = b_sig[BW] ? BW'(-b_sig) : BW'(b_sig);

    pidaw_mul #(
        .AW (AW),
        .BW (BW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a_mag   (a_mag),
        .b_mag   (b_mag),
        .done    (mul_done),
        .product (prod)
    );

    pidaw_div #(
        .PW (PW),
        .RW (DW - 1)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod),
        .divisor  (dt_reg),
        .done     (div_done),
        .quotient (quo)
    );

    // fractional product: drop fraction bits toward zero, limit magnitude
    assign prod_shift = prod >> FRAC_BITS;
    assign frac_mag   = (prod_shift > LIMIT_P) ? LIMIT_P : prod_shift;
    assign frac_term  = neg_reg ? -$signed(TERM_W'(frac_mag)) : $signed(TERM_W'(frac_mag));

    // derivative quotient, same limit
    assign quo_mag  = (quo > LIMIT_P) ? LIMIT_P : quo;
    assign quo_term = neg_reg ? -$signed(TERM_W'(quo_mag)) : $signed(TERM_W'(quo_mag));

    // saturating integral update
    assign integ_add = SW'(integ_reg) + SW'(frac_term);

    always_comb begin
        if (integ_add > IMAX_S) begin
            integ_sat = IMAX_S[INTEG_W-1:0];
        end else if (integ_add < IMIN_S) begin
            integ_sat = IMIN_S[INTEG_W-1:0];
        end else begin
            integ_sat = integ_add[INTEG_W-1:0];
        end
    end

    // three-term sum, saturated to data width
    assign sum3 = SW'(pterm_reg) + SW'(iterm_reg) + SW'(dterm_reg);

    always_comb begin
        if (sum3 > DMAX_S) begin
            raw_sat = DMAX_S[DW-1:0];
        end else if (sum3 < DMIN_S) begin
            raw_sat = DMIN_S[DW-1:0];
        end else begin
            raw_sat = sum3[DW-1:0];
        end
    end

    // ceiling first, then floor, so floor wins when the limits cross
    assign drv_hi = (raw_reg > hi_reg) ? hi_reg : raw_reg;
    assign drv_c  = (drv_hi < lo_reg) ? lo_reg : drv_hi;

    // next state
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_ERR;
                    op_next    = OP_INC;
                end
            end
            ST_ERR: state_next = ST_MSTART;
            ST_MSTART: state_next = ST_MWAIT;
            ST_MWAIT: begin
                if (mul_done) begin
                    case (op_reg)
                        OP_INC: begin
                            state_next = ST_MSTART;
                            op_next    = OP_PROP;
                        end
                        OP_PROP: begin
                            state_next = ST_MSTART;
                            op_next    = OP_INTEG;
                        end
                        OP_INTEG: begin
                            // zero period leaves the derivative term at zero
                            state_next = (dt_reg != '0) ? ST_MSTART : ST_SUM;
                            op_next    = OP_DERIV;
                        end
                        OP_DERIV: state_next = ST_DWAIT;
                        OP_CORR:  state_next = ST_IDLE;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DWAIT: begin
                if (div_done) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: state_next = ST_EMIT;
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_MSTART;
                    op_next    = OP_CORR;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        take_in   = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        emit      = 1'b0;
        unique case (state_reg)
            ST_IDLE:   take_in   = s_valid;
            ST_MSTART: mul_start = 1'b1;
            ST_MWAIT:  div_start = mul_done && (op_reg == OP_DERIV);
            ST_EMIT:   emit      = !m_valid_reg || m_ready;
            default: begin
                take_in = 1'b0;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    // control state and loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_INC;
            m_valid_reg  <= 1'b0;
            integ_reg    <= '0;
            prev_err_reg <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_MWAIT && mul_done) begin
                if (op_reg == OP_INC || op_reg == OP_CORR) begin
                    integ_reg <= integ_sat;
                end
                if (op_reg == OP_CORR) begin
                    prev_err_reg <= err_reg;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (take_in) begin
            err_reg <= err_sat;
        end
        if (state_reg == ST_ERR) begin
            diff_reg <= (DW+1)'(err_reg) - (DW+1)'(prev_err_reg);
        end
        if (mul_start) begin
            neg_reg <= a_sig[AW-1] ^ b_sig[BW];
        end
        if (state_reg == ST_MWAIT && mul_done) begin
            case (op_reg)
                OP_PROP:  pterm_reg <= frac_term;
                OP_INTEG: begin
                    iterm_reg <= frac_term;
                    dterm_reg <= '0;
                end
                default:  pterm_reg <= pterm_reg;
            endcase
        end
        if (state_reg == ST_DWAIT && div_done) begin
            dterm_reg <= quo_term;
        end
        if (state_reg == ST_SUM) begin
            raw_reg <= raw_sat;
        end
        if (emit) begin
            drv_reg     <= drv_c;
            m_drive_reg <= drv_c;
            m_raw_reg   <= raw_reg;
            m_clamp_reg <= (drv_c != raw_reg);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_drive       = m_drive_reg;
    assign m_raw_drive   = m_raw_reg;
    assign m_was_clamped = m_clamp_reg;

endmodule
`default_nettype wire

// ===== rtl/core/pidaw_mul.sv =====
// bit-serial shift-add multiplier for unsigned magnitudes
`default_nettype none
module pidaw_mul #(
    parameter int AW = 48,
    parameter int BW = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [AW-1:0]    a_mag,
    input  wire logic [BW-1:0]    b_mag,
    output logic                  done,
    output logic [AW+BW-1:0]      product
);
    import pidaw_pkg::*;

    localparam int CW = (BW > 1) ? $clog2(BW) : 1;

    logic [AW-1:0] a_reg;
    logic [AW-1:0] hi_reg;
    logic [BW-1:0] lo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [AW:0]   sum;

    // one multiplier bit per cycle
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : {(AW+1){1'b0}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(BW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a_mag;
            hi_reg <= '0;
            lo_reg <= b_mag;
        end else if (busy_reg) begin
            hi_reg <= sum[AW:1];
            lo_reg <= {sum[0], lo_reg[BW-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule
`default_nettype wire

// ===== rtl/core/pidaw_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module pidaw_div #(
    parameter int PW = 80,
    parameter int RW = 31
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [PW-1:0] dividend,
    input  wire logic [RW-1:0] divisor,
    output logic               done,
    output logic [PW-1:0]      quotient
);
    import pidaw_pkg::*;

    localparam int CW = $clog2(PW);

    logic [PW-1:0] dvd_reg;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [RW:0]   shifted;
    logic [RW+1:0] trial;
    logic          ge;

    assign shifted = {rem_reg, dvd_reg[PW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dsr_reg};
    assign ge      = !trial[RW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(PW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in where dividend bits leave
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[PW-2:0], ge};
            rem_reg <= ge ? trial[RW-1:0] : shifted[RW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule
`default_nettype wire

// ===== bench/pid_controller_back_calc_antiwindup_unit_tb.sv =====
// self-checking testbench for the pid controller with back-calculation anti-windup
`timescale 1ns / 100ps
`default_nettype none
module pid_controller_back_calc_antiwindup_unit_tb;
    import pidaw_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;
    localparam longint TERM_CAP = 64'sd1 <<< 60;

    typedef struct packed {
        logic signed [DW-1:0] drive;
        logic signed [DW-1:0] raw_drive;
        logic                 was_clamped;
    } pid_out_t;

    logic aclk;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DW-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic signed [DW-1:0] s_process_value;
    logic m_valid;
    logic m_ready;
    logic signed [DW-1:0] m_drive;
    logic signed [DW-1:0] m_raw_drive;
    logic m_was_clamped;

    pid_controller_back_calc_antiwindup_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_process_value(s_process_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_drive(m_drive),
        .m_raw_drive(m_raw_drive), .m_was_clamped(m_was_clamped)
    );

    // shadow of the register file
    logic signed [DW-1:0] kp, ki, kd, setpoint, floor_lim, ceil_lim;
    logic [DW-2:0] period;
    logic [WGAIN_W-1:0] aw_gain;
    // shadow of the controller state
    longint integ_acc;
    longint prev_err;

    logic signed [DW-1:0] sample_q[$];
    pid_out_t pid_out_q[$];
    int sender_gap_pct;
    int receiver_gap_pct;
    int n_errors = 0;
    int n_results;
    int hold_left;
    bit hold_done;
    int quiet_cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] mag(input longint x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function automatic longint sat_to(input longint x, input int w);
        longint hi, lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        return x > hi ? hi : (x < lo ? lo : x);
    endfunction

    function automatic longint cap_term(input logic [127:0] p, input bit neg);
        longint r;
        if (p > 128'(TERM_CAP)) p = 128'(TERM_CAP);
        r = longint'(p[63:0]);
        return neg ? -r : r;
    endfunction

    // product of two fractional values, truncated toward zero
    function automatic longint frac_mul(input longint a, input longint b);
        logic [127:0] p;
        p = {64'd0, mag(a)} * {64'd0, mag(b)};
        return cap_term(p >> FB, (a < 0) != (b < 0));
    endfunction

    function automatic longint frac_mul_div(input longint a, input longint b,
                                            input logic [63:0] d);
        logic [127:0] p;
        p = {64'd0, mag(a)} * {64'd0, mag(b)};
        return cap_term(p / {64'd0, d}, (a < 0) != (b < 0));
    endfunction

    // one controller step, updates the shadow state
    function automatic pid_out_t pid_predict(input logic signed [DW-1:0] pv);
        longint err, pterm, iterm, dterm, raw, drv, dt;
        pid_out_t o;
        dt = longint'({33'd0, period});
        err = sat_to(longint'(setpoint) - longint'(pv), DW);
        pterm = frac_mul(longint'(kp), err);
        integ_acc = sat_to(integ_acc + frac_mul(err, dt), INTEG_W);
        iterm = frac_mul(longint'(ki), integ_acc);
        dterm = dt != 0 ? frac_mul_div(longint'(kd), err - prev_err, 64'(dt)) : 0;
        raw = sat_to(pterm + iterm + dterm, DW);
        drv = raw > longint'(ceil_lim) ? longint'(ceil_lim) : raw;
        drv = drv < longint'(floor_lim) ? longint'(floor_lim) : drv;
        integ_acc = sat_to(integ_acc + frac_mul(drv - raw, longint'({47'd0, aw_gain})),
                           INTEG_W);
        prev_err = err;
        o.drive = drv[DW-1:0];
        o.raw_drive = raw[DW-1:0];
        o.was_clamped = drv != raw;
        return o;
    endfunction

    // register shadow follows each accepted config transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            kp <= 32'sd65536;
            ki <= '0;
            kd <= '0;
            setpoint <= '0;
            period <= 31'd65536;
            floor_lim <= '0;
            ceil_lim <= 32'sd6553600;
            aw_gain <= 17'd6554;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_PROP_GAIN: kp <= cfg_data;
                REG_INTEG_GAIN: ki <= cfg_data;
                REG_DERIV_GAIN: kd <= cfg_data;
                REG_TARGET_VALUE: setpoint <= cfg_data;
                REG_SAMPLE_PERIOD: period <= cfg_data[DW-2:0];
                REG_DRIVE_FLOOR: floor_lim <= cfg_data;
                REG_DRIVE_CEILING: ceil_lim <= cfg_data;
                REG_WINDUP_GAIN: aw_gain <= cfg_data[WGAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // sample driver: predicts on each accepted transfer, then refills the slot
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_process_value <= '0;
            integ_acc = 0;
            prev_err = 0;
        end else begin
            if (s_valid && s_ready)
                pid_out_q.push_back(pid_predict(s_process_value));
            if (!s_valid || s_ready) begin
                if (sample_q.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
                    s_valid <= 1'b1;
                    s_process_value <= sample_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure and one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
            n_results = 0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (pid_out_q.size() == 0) begin
                    $display("%0t: unexpected result drive=%0d raw=%0d clamp=%0b", $time,
                             m_drive, m_raw_drive, m_was_clamped);
                    n_errors++;
                end else begin
                    pid_out_t e;
                    e = pid_out_q.pop_front();
                    if (e.drive !== m_drive) begin
                        $display("%0t: drive expected %0d actual %0d", $time, e.drive, m_drive);
                        n_errors++;
                    end
                    if (e.raw_drive !== m_raw_drive) begin
                        $display("%0t: raw_drive expected %0d actual %0d", $time,
                                 e.raw_drive, m_raw_drive);
                        n_errors++;
                    end
                    if (e.was_clamped !== m_was_clamped) begin
                        $display("%0t: was_clamped expected %0b actual %0b", $time,
                                 e.was_clamped, m_was_clamped);
                        n_errors++;
                    end
                end
                // stall the output long enough for the input side to back up
                if (n_results == 300 && !hold_done) begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= $urandom_range(99) >= receiver_gap_pct;
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [DW-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [DW-1:0] p, input logic [DW-1:0] i,
                             input logic [DW-1:0] d, input logic [DW-1:0] sp,
                             input logic [DW-1:0] dt, input logic [DW-1:0] lo,
                             input logic [DW-1:0] hi, input logic [DW-1:0] aw);
        write_reg(REG_PROP_GAIN, p);
        write_reg(REG_INTEG_GAIN, i);
        write_reg(REG_DERIV_GAIN, d);
        write_reg(REG_TARGET_VALUE, sp);
        write_reg(REG_SAMPLE_PERIOD, dt);
        write_reg(REG_DRIVE_FLOOR, lo);
        write_reg(REG_DRIVE_CEILING, hi);
        write_reg(REG_WINDUP_GAIN, aw);
    endtask

    // the anti-windup product still runs after the last result leaves
    task automatic drain;
        while (sample_q.size() > 0 || s_valid || pid_out_q.size() > 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // mostly values near the operating range, some full range and extremes
    function automatic logic [DW-1:0] pick_value(input int span);
        case ($urandom_range(7))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            2: return 32'($signed($urandom_range(2 * span)) - span) <<< 8;
            default: return 32'($signed($urandom_range(2 * span)) - span);
        endcase
    endfunction

    function automatic logic [DW-1:0] pick_period;
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(3);
            default: return $urandom_range(1 << 17, 1);
        endcase
    endfunction

    initial begin
        logic [DW-1:0] lo, hi;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sender_gap_pct = 23;
        receiver_gap_pct = 86;
        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: extremes of the sample
        sample_q.push_back(32'sh0);
        sample_q.push_back(32'sh7fff_ffff);
        sample_q.push_back(32'sh8000_0000);
        sample_q.push_back(-32'sh1);
        sample_q.push_back(-32'sh0065_0000);
        sample_q.push_back(32'sh1);
        drain();

        // extreme gains, zero sample period, floor above ceiling, widest windup gain
        write_all(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h8000_0000, 32'h0010_0000, 32'hfff0_0000, 32'h0001_ffff);
        sample_q.push_back(32'sh7fff_ffff);
        sample_q.push_back(32'sh8000_0000);
        sample_q.push_back(32'sh0);
        sample_q.push_back(32'sh1234_5678);
        drain();

        // smallest period, unity windup, symmetric limits, saturating derivative
        write_all(32'h0001_0000, 32'h0000_8000, 32'h8000_0000, 32'h7fff_ffff,
                  32'h0000_0001, 32'hff9c_0000, 32'h0064_0000, 32'h0001_0000);
        sample_q.push_back(32'sh8000_0000);
        sample_q.push_back(32'sh7fff_ffff);
        sample_q.push_back(32'sh0);
        sample_q.push_back(-32'sh1);
        drain();

        // zero windup gain, largest period
        write_all(32'h0002_0000, 32'h7fff_ffff, 32'h0000_0100, 32'h0000_0000,
                  32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
        sample_q.push_back(32'sh0001_0000);
        sample_q.push_back(-32'sh7fff_0000);
        sample_q.push_back(32'sh7fff_ffff);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            sender_gap_pct = ph < 2 ? 23 : (ph < 4 ? 86 : 0);
            receiver_gap_pct = ph < 2 ? 86 : (ph < 4 ? 23 : 0);
            lo = pick_value(1 << 22);
            hi = pick_value(1 << 22);
            if ($urandom_range(3) != 0 && $signed(lo) > $signed(hi)) begin
                logic [DW-1:0] t;
                t = lo;
                lo = hi;
                hi = t;
            end
            write_all(pick_value(1 << 18), pick_value(1 << 16), pick_value(1 << 16),
                      pick_value(1 << 22), pick_period(), lo, hi,
                      $urandom_range(3) == 0 ? $urandom_range(17'h1_ffff)
                                             : $urandom_range(65536));
            repeat (160) sample_q.push_back(pick_value(1 << 22));
            drain();
        end

        repeat (300) @(posedge aclk);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
